FILE: rtl/core/osl_pkg.sv
package osl_pkg;

	localparam int unsigned KEY_W          = 32;
	localparam int unsigned OP_W           = 3;
	localparam int unsigned SLOT_IDX_W     = 4;
	localparam int unsigned SLOT_COUNT_DEF = 12;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 3'd0,
		OP_FRONT  = 3'd1,
		OP_BACK   = 3'd2,
		OP_READ   = 3'd3,
		OP_CLEAR  = 3'd4
	} op_e;

	// Command held for the duration of one operation
	typedef struct packed {
		logic                  valid;
		op_e                   op;
		logic [KEY_W-1:0]      key;
		logic [SLOT_IDX_W-1:0] idx;
	} cmd_t;

	// Ripple information handed from one cell to the next
	typedef struct packed {
		logic hit;    // key matched in an earlier slot
		logic empty;  // empty slot seen in an earlier slot
		logic seg;    // previous cell lies in the move-to-back run
	} chain_t;

endpackage

FILE: rtl/core/osl_cell.sv
module osl_cell #(
	parameter int unsigned SLOT_IDX = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  osl_pkg::cmd_t               cmd,
	input  logic [osl_pkg::KEY_W-1:0]   prev_key,
	input  logic [osl_pkg::KEY_W-1:0]   next_key,
	input  osl_pkg::chain_t             chain_in,
	output osl_pkg::chain_t             chain_out,
	input  logic                        any_hit,
	output logic [osl_pkg::KEY_W-1:0]   slot_key,
	output logic [osl_pkg::KEY_W-1:0]   rd_key
);

	logic [osl_pkg::KEY_W-1:0] key_q;
	logic match;
	logic is_empty;
	logic first_hit;
	logic first_empty;
	logic in_seg;
	logic next_nz;

	// Local compares and ripple terms
	assign match       = (key_q == cmd.key);
	assign is_empty    = (key_q == '0);
	assign first_hit   = match & ~chain_in.hit;
	assign first_empty = is_empty & ~chain_in.empty;
	assign in_seg      = first_hit | (chain_in.seg & ~is_empty);
	assign next_nz     = (next_key != '0);

	assign chain_out.hit   = chain_in.hit | match;
	assign chain_out.empty = chain_in.empty | is_empty;
	assign chain_out.seg   = in_seg;

	assign slot_key = key_q;

	// Drive this slot onto the read bus when addressed
	assign rd_key = (cmd.op == osl_pkg::OP_READ && 32'(cmd.idx) == 32'(SLOT_IDX))
		? key_q : '0;

	// Update the slot for the current command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cmd.valid) begin
			unique case (cmd.op)
				osl_pkg::OP_INSERT: begin
					if (first_empty) key_q <= cmd.key;
				end
				osl_pkg::OP_FRONT: begin
					// slots up to and including the first hit take the neighbor below; slot 0 takes the key
					if (any_hit && !chain_in.hit) key_q <= prev_key;
				end
				osl_pkg::OP_BACK: begin
					if (in_seg) key_q <= next_nz ? next_key : cmd.key;
				end
				osl_pkg::OP_CLEAR: begin
					key_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/ordered_slot_list.sv
// Ordered slot list with move-to-front and move-to-back.
// Holds SLOT_COUNT 32-bit keys in a row of cells; key zero marks an empty slot.
// Command channel: operation, key and slot_index transfer at a rising edge
// where start is high and busy is low. busy then stays high for one cycle.
// Result channel: success and read_key are valid for exactly one cycle,
// marked by done; the receiver takes them as they come and cannot stall.
// The transfer edge registers the command, and the next edge updates the
// cells and registers the result, with done raised. The block takes a new
// operation only once the last is through; the next command may transfer
// in the cycle that done is shown. The compare and update run across all
// cells at once, with first-hit and first-empty rippled along the row.
// Operations: insert into the first empty slot, move to front, move to
// back, read by index (zero beyond the last slot), clear. Unused codes
// leave the list unchanged and return zeros.
// Reset: all slots empty, no command in flight, done low.
module ordered_slot_list #(
	parameter int unsigned SLOT_COUNT = osl_pkg::SLOT_COUNT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [osl_pkg::OP_W-1:0]         operation,
	input  logic [osl_pkg::KEY_W-1:0]        key,
	input  logic [osl_pkg::SLOT_IDX_W-1:0]   slot_index,
	output logic                             done,
	output logic                             success,
	output logic [osl_pkg::KEY_W-1:0]        read_key
);

	osl_pkg::cmd_t   cmd_q;
	osl_pkg::chain_t chain [SLOT_COUNT+1];
	logic [osl_pkg::KEY_W-1:0] slot_key [SLOT_COUNT];
	logic [osl_pkg::KEY_W-1:0] rd_key   [SLOT_COUNT];
	logic [osl_pkg::KEY_W-1:0] rd_sum;
	logic any_hit;
	logic any_empty;
	logic done_q;
	logic success_q;
	logic [osl_pkg::KEY_W-1:0] read_key_q;

	assign busy = cmd_q.valid;

	// Hold the command for its compute cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q.valid <= 1'b0;
			cmd_q.op    <= osl_pkg::OP_INSERT;
			cmd_q.key   <= '0;
			cmd_q.idx   <= '0;
		end else if (start && !cmd_q.valid) begin
			cmd_q.valid <= 1'b1;
			cmd_q.op    <= osl_pkg::op_e'(operation);
			cmd_q.key   <= key;
			cmd_q.idx   <= slot_index;
		end else begin
			cmd_q.valid <= 1'b0;
		end
	end

	assign chain[0] = '0;

	// Row of slot cells
	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
		logic [osl_pkg::KEY_W-1:0] prev_k;
		logic [osl_pkg::KEY_W-1:0] next_k;

		if (i == 0) begin : g_first
			assign prev_k = cmd_q.key;
		end else begin : g_mid
			assign prev_k = slot_key[i-1];
		end

		if (i == SLOT_COUNT - 1) begin : g_last
			assign next_k = '0;
		end else begin : g_inner
			assign next_k = slot_key[i+1];
		end

		osl_cell #(
			.SLOT_IDX(i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd_q),
			.prev_key (prev_k),
			.next_key (next_k),
			.chain_in (chain[i]),
			.chain_out(chain[i+1]),
			.any_hit  (any_hit),
			.slot_key (slot_key[i]),
			.rd_key   (rd_key[i])
		);
	end

	assign any_hit   = chain[SLOT_COUNT].hit;
	assign any_empty = chain[SLOT_COUNT].empty;

	// Merge the read bus
	always_comb begin
		rd_sum = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			rd_sum = rd_sum | rd_key[i];
		end
	end

	// Register the result for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q     <= 1'b0;
			success_q  <= 1'b0;
			read_key_q <= '0;
		end else begin
			done_q     <= cmd_q.valid;
			success_q  <= 1'b0;
			read_key_q <= '0;
			if (cmd_q.valid) begin
				unique case (cmd_q.op) inside
					osl_pkg::OP_INSERT: success_q <= any_empty;
					osl_pkg::OP_FRONT,
					osl_pkg::OP_BACK:   success_q <= any_hit;
					osl_pkg::OP_READ:   read_key_q <= rd_sum;
					default: begin
					end
				endcase
			end
		end
	end

	assign done     = done_q;
	assign success  = success_q;
	assign read_key = read_key_q;

endmodule

FILE: tb/sv/ordered_slot_list_tb.sv
`default_nettype none

module ordered_slot_list_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import osl_pkg::*;

	localparam int unsigned SLOTS     = SLOT_COUNT_DEF;
	localparam int unsigned MAX_CYCLE = 100000;
	localparam int unsigned RAND_OPS  = 950;

	typedef struct {
		logic             success;
		logic [KEY_W-1:0] read_key;
	} list_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [OP_W-1:0]       operation;
	logic [KEY_W-1:0]      key;
	logic [SLOT_IDX_W-1:0] slot_index;
	logic                  done;
	logic                  success;
	logic [KEY_W-1:0]      read_key;

	// Shadow copy of the slot list and results still owed by the block
	logic [KEY_W-1:0] slot_shadow [SLOTS];
	list_result_t     pending_results [$];
	logic [KEY_W-1:0] key_pool [8];
	bit               idle_on;
	int               err_cnt;

	ordered_slot_list i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.key        (key),
		.slot_index (slot_index),
		.done       (done),
		.success    (success),
		.read_key   (read_key)
	);

	always #1 clk = ~clk;

	// Lowest slot holding k, or SLOTS when none does
	function automatic int lowest_slot(input logic [KEY_W-1:0] k);
		for (int i = 0; i < SLOTS; i++) begin
			if (slot_shadow[i] == k) begin
				return i;
			end
		end
		return SLOTS;
	endfunction

	// Apply one operation to the shadow list and queue the result it owes
	function automatic void predict_list_op(input logic [OP_W-1:0] op,
			input logic [KEY_W-1:0] k, input logic [SLOT_IDX_W-1:0] idx);
		list_result_t res;
		int           pos;
		res.success  = 1'b0;
		res.read_key = '0;
		case (op)
			OP_INSERT: begin
				pos = lowest_slot('0);
				if (pos < SLOTS) begin
					slot_shadow[pos] = k;
					res.success = 1'b1;
				end
			end
			OP_FRONT: begin
				pos = lowest_slot(k);
				if (pos < SLOTS) begin
					for (int j = pos; j > 0; j--) begin
						slot_shadow[j] = slot_shadow[j-1];
					end
					slot_shadow[0] = k;
					res.success = 1'b1;
				end
			end
			OP_BACK: begin
				pos = lowest_slot(k);
				if (pos < SLOTS) begin
					while (pos + 1 < SLOTS && slot_shadow[pos+1] != '0) begin
						slot_shadow[pos] = slot_shadow[pos+1];
						pos++;
					end
					slot_shadow[pos] = k;
					res.success = 1'b1;
				end
			end
			OP_READ: begin
				if (idx < SLOTS) begin
					res.read_key = slot_shadow[idx];
				end
			end
			OP_CLEAR: begin
				for (int j = 0; j < SLOTS; j++) begin
					slot_shadow[j] = '0;
				end
			end
			default: ;
		endcase
		pending_results.push_back(res);
	endfunction

	// Drive one command and hold it until the block takes the transfer
	task automatic send_cmd(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
			input logic [SLOT_IDX_W-1:0] idx);
		@(negedge clk);
		while (idle_on && $urandom_range(0, 99) < 30) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start      <= 1'b1;
		operation  <= op;
		key        <= k;
		slot_index <= idx;
		do begin
			@(posedge clk);
		end while (busy !== 1'b0);
		predict_list_op(op, k, idx);
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5) begin
			return '0;
		end else if (r < 15) begin
			return $urandom();
		end
		return key_pool[$urandom_range(0, 7)];
	endfunction

	// Reads at both ends of the index range on the empty list
	task automatic test_read_range();
		send_cmd(OP_READ, 32'hFFFF_FFFF, 4'd0);
		send_cmd(OP_READ, 32'h0, 4'd15);
	endtask

	// Fill every slot, with one duplicate, then overflow
	task automatic test_fill_list();
		send_cmd(OP_INSERT, 32'hFFFF_FFFF, 4'd0);
		send_cmd(OP_INSERT, 32'h8000_0001, 4'd15);
		send_cmd(OP_INSERT, 32'h8000_0001, 4'd0);
		for (int i = 3; i < SLOTS; i++) begin
			send_cmd(OP_INSERT, 32'h100 + i, 4'(i));
		end
		send_cmd(OP_INSERT, 32'h7FFF_FFFE, 4'd0);
	endtask

	// Moves on a full list, duplicates, a missing key, reads at the edge
	task automatic test_moves();
		send_cmd(OP_FRONT, 32'h8000_0001, 4'd0);
		send_cmd(OP_BACK, 32'h8000_0001, 4'd0);
		send_cmd(OP_FRONT, 32'h0000_1234, 4'd0);
		send_cmd(OP_READ, 32'h0, 4'd11);
		send_cmd(OP_READ, 32'h0, 4'd12);
	endtask

	// Key zero treated as an ordinary key against empty slots
	task automatic test_zero_key();
		send_cmd(OP_CLEAR, 32'hFFFF_FFFF, 4'd15);
		send_cmd(OP_INSERT, 32'h0, 4'd0);
		send_cmd(OP_FRONT, 32'h0, 4'd0);
		send_cmd(OP_INSERT, 32'h5A5A_A5A5, 4'd0);
		send_cmd(OP_BACK, 32'h0, 4'd1);
	endtask

	// Codes past clear do nothing and return zeros
	task automatic test_unused_ops();
		send_cmd(OP_W'(5), 32'h5A5A_A5A5, 4'd0);
		send_cmd(OP_W'(7), 32'hFFFF_FFFF, 4'd15);
	endtask

	// Mostly inserts, moves and reads over a small key pool, with rare clears and unused codes
	task automatic test_random_traffic(input int count);
		logic [OP_W-1:0] op;
		int              pick;
		key_pool[0] = 32'hFFFF_FFFF;
		for (int i = 1; i < 8; i++) begin
			key_pool[i] = $urandom();
		end
		for (int n = 0; n < count; n++) begin
			idle_on = !(n >= count / 3 && n < 2 * count / 3);
			pick    = $urandom_range(0, 99);
			if (pick < 35) begin
				op = OP_INSERT;
			end else if (pick < 55) begin
				op = OP_FRONT;
			end else if (pick < 75) begin
				op = OP_BACK;
			end else if (pick < 95) begin
				op = OP_READ;
			end else if (pick < 97) begin
				op = OP_CLEAR;
			end else begin
				op = OP_W'($urandom_range(5, 7));
			end
			send_cmd(op, pick_key(), SLOT_IDX_W'($urandom_range(0, 15)));
		end
		idle_on = 1'b1;
	endtask

	// Compare each result strobe with the oldest expectation
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with no expectation waiting");
				err_cnt++;
			end else begin
				want = pending_results.pop_front();
				if (success !== want.success) begin
					$error("success mismatch: expected %0b, actual %0b",
						want.success, success);
					err_cnt++;
				end
				if (read_key !== want.read_key) begin
					$error("read_key mismatch: expected %h, actual %h",
						want.read_key, read_key);
					err_cnt++;
				end
			end
		end
	end

	// Bound the run
	initial begin
		repeat (MAX_CYCLE) @(posedge clk);
		$display("ordered_slot_list_tb: FAIL");
		$finish;
	end

	initial begin
		clk        = 1'b0;
		arst_n     = 1'b0;
		start      = 1'b0;
		operation  = '0;
		key        = '0;
		slot_index = '0;
		idle_on    = 1'b1;
		err_cnt    = 0;
		for (int i = 0; i < SLOTS; i++) begin
			slot_shadow[i] = '0;
		end
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		test_read_range();
		test_fill_list();
		test_moves();
		test_zero_key();
		test_unused_ops();
		test_random_traffic(RAND_OPS);

		// Drop start and drain the remaining results
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
		if (err_cnt == 0) begin
			$display("ordered_slot_list_tb: PASS");
		end else begin
			$display("ordered_slot_list_tb: FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
